// File: hdl/tmtf_pkg.sv
// shared types and constants of the trimmed mean temperature filter
// no dependencies; imported by every module of the block
`default_nettype none

package tmtf_pkg;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // one word moving down the sorter chain
    typedef struct packed {
        logic    valid;
        sample_t data;
    } tmtf_link_t;

    typedef enum logic [1:0] {
        KIND_SEED   = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_SPARE  = 2'd3
    } kind_t;

    localparam logic [ADDR_W-1:0] ADDR_KELVIN_ADJUST = 3'd0;

    localparam logic signed [7:0]  KELVIN_ADJUST_RESET = -8'sd13;
    localparam logic signed [11:0] CELSIUS_OFFSET      = 12'sd273;
    localparam logic signed [11:0] FAHRENHEIT_OFFSET   = 12'sd32;

    // x / 5 == (x * 52429) >> 18 for x below 52428
    localparam logic [15:0] RECIP5       = 16'd52429;
    localparam int unsigned RECIP5_SHIFT = 18;

endpackage

`default_nettype wire

// File: hdl/tmtf_sort_cell.sv
// one cell of the sorter chain: holds one value, passes the other on
// depends on tmtf_pkg
`default_nettype none

module tmtf_sort_cell
    import tmtf_pkg::*;
#(
    parameter bit KEEP_LOW = 1'b1
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       clear,
    input  wire tmtf_link_t link_in,
    output tmtf_link_t      link_out
);

    logic       held_v_reg;
    sample_t    held_reg;
    logic       out_v_reg;
    sample_t    out_data_reg;
    logic       in_lower;

    assign in_lower       = (link_in.data < held_reg);
    assign link_out.valid = out_v_reg;
    assign link_out.data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            held_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else if (link_in.valid) begin
            if (!held_v_reg) begin
                held_v_reg <= 1'b1;
                out_v_reg  <= 1'b0;
            end else begin
                out_v_reg <= 1'b1;
            end
        end else begin
            out_v_reg <= 1'b0;
        end
    end

    // keep the lower (or higher) of held and incoming, pass the other
    always_ff @(posedge aclk) begin
        if (link_in.valid) begin
            if (!held_v_reg) begin
                held_reg <= link_in.data;
            end else if (in_lower == KEEP_LOW) begin
                held_reg     <= link_in.data;
                out_data_reg <= held_reg;
            end else begin
                out_data_reg <= link_in.data;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/tmtf_div.sv
// divider by a constant through reciprocal multiplication; the dividend and then the quotient are registered
// depends on tmtf_pkg
`default_nettype none

module tmtf_div
    import tmtf_pkg::*;
#(
    parameter int unsigned DIVISOR    = 18,
    parameter int unsigned DIVIDEND_W = 15,
    parameter int unsigned QUOT_W     = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    output logic      [QUOT_W-1:0]     quotient,
    output logic                       done
);

    // (x * RECIP) >> SHIFT equals x / DIVISOR for every x below 2**DIVIDEND_W
    localparam int unsigned     SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
    localparam int unsigned     RECIP_W = DIVIDEND_W + 1;
    localparam int unsigned     PROD_W  = DIVIDEND_W + RECIP_W;
    localparam longint unsigned RECIP   =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    logic [DIVIDEND_W-1:0] dvd_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [QUOT_W-1:0]     quot_reg;
    logic [PROD_W-1:0]     prod;

    assign prod     = PROD_W'(dvd_reg) * PROD_W'(RECIP);
    assign quotient = quot_reg;
    assign done     = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    // dividend is registered first so the multiply starts from a flop
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
        end
        if (busy_reg) begin
            quot_reg <= prod[SHIFT +: QUOT_W];
        end
    end

endmodule

`default_nettype wire

// File: hdl/trimmed_mean_temperature_filter_core.sv
// top level of the trimmed mean temperature filter: sample ring, sorter chain,
// divider, unit conversion and apb register; depends on tmtf_pkg,
// tmtf_sort_cell and tmtf_div
//
// usage:
//   s_ channel takes one word per item: s_kind (seed, sample, query) and
//   s_sample. seed fills all DEPTH ring slots, a nonzero sample replaces the
//   oldest one, query and the spare kind store nothing. every item returns one
//   m_ word: kelvin, celsius and fahrenheit of the mean of the ring with the
//   TR lowest and TR highest values dropped.
//   from acceptance to m_valid the ring is rotated through a chain of 2*TR
//   sorter cells one value per cycle (TR being TRIM cut to (DEPTH-1)/2 when
//   2*TRIM >= DEPTH), then the sum of the middle values goes through a
//   reciprocal multiplication with registered dividend and quotient, and the
//   temp, mag and mul states convert the units. one item is in work at a time;
//   s_ready is high while the block waits for an item, also while a result
//   waits at m_, so the next item can be accepted in the cycle m_valid rises.
//   if the receiver stalls, the result is held in the output register and the
//   next item stops before its result until that word is taken.
//   reset clears the ring to zero and sets kelvin_adjust (apb offset 0) to -13.
`default_nettype none

module trimmed_mean_temperature_filter_core
    import tmtf_pkg::*;
#(
    parameter int unsigned DEPTH = 30,
    parameter int unsigned TRIM  = 6
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_kind,
    input  wire logic [9:0]         s_sample,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [11:0]      m_kelvin,
    output logic signed [10:0]      m_celsius,
    output logic signed [11:0]      m_fahrenheit
);

    localparam int unsigned TR    = (2 * TRIM >= DEPTH) ? (DEPTH - 1) / 2 : TRIM;
    localparam int unsigned NKEEP = DEPTH - 2 * TR;
    localparam int unsigned NCELL = 2 * TR;
    localparam int unsigned SUM_W = $clog2(DEPTH * 1023 + 1);
    localparam int unsigned FC_W  = $clog2(DEPTH + 1);
    localparam int unsigned MC_W  = $clog2(NKEEP + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_FEED = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_TEMP = 7'b0001000,
        S_MAG  = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [7:0] adj_reg;
    sample_t           ring_reg [DEPTH];
    logic [FC_W-1:0]   feed_cnt_reg;
    logic [MC_W-1:0]   mid_cnt_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic [SUM_W-1:0]  sum_final;
    logic              in_accept;
    logic              cfg_write;
    logic              feeding;
    logic              last_mid;
    tmtf_link_t        link [NCELL+1];
    tmtf_link_t        mid;
    logic              div_done;
    logic [9:0]        div_q;

    logic signed [11:0] kelvin_calc;
    logic signed [11:0] celsius_calc;
    logic signed [11:0] kel_reg;
    logic signed [10:0] cel_reg;
    logic signed [14:0] cel_ext;
    logic signed [14:0] cel_x9;
    logic [14:0]        cel_x9_mag;
    logic [12:0]        mag_reg;
    logic               neg_reg;
    logic [28:0]        prod;
    logic [10:0]        q_reg;
    logic signed [11:0] fq;
    logic signed [11:0] fahr_calc;

    logic               m_valid_reg;
    logic signed [11:0] m_kelvin_reg;
    logic signed [10:0] m_celsius_reg;
    logic signed [11:0] m_fahrenheit_reg;

    // ---------------- apb register ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adj_reg <= KELVIN_ADJUST_RESET;
        end else if (cfg_write && paddr[ADDR_W-1:2] == ADDR_KELVIN_ADJUST[ADDR_W-1:2]) begin
            adj_reg <= signed'(pwdata[7:0]);
        end
    end

    always_comb begin
        if (paddr[ADDR_W-1:2] == ADDR_KELVIN_ADJUST[ADDR_W-1:2]) begin
            prdata = {{(DATA_W-8){adj_reg[7]}}, adj_reg};
        end else begin
            prdata = '0;
        end
    end

    // ---------------- control ----------------
    assign s_ready   = (state_reg == S_IDLE);
    assign in_accept = s_valid && s_ready;
    assign feeding   = (state_reg == S_FEED) && (feed_cnt_reg != FC_W'(DEPTH));
    assign last_mid  = (state_reg == S_FEED) && mid.valid
                       && (mid_cnt_reg == MC_W'(NKEEP - 1));
    assign sum_final = acc_reg + SUM_W'(mid.data);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_accept) state_next = S_FEED;
            S_FEED: if (last_mid) state_next = S_DIV;
            S_DIV:  if (div_done) state_next = S_TEMP;
            S_TEMP: state_next = S_MAG;
            S_MAG:  state_next = S_MUL;
            S_MUL:  state_next = S_OUT;
            S_OUT:  if (!m_valid_reg || m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            feed_cnt_reg <= '0;
            mid_cnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (in_accept) begin
                feed_cnt_reg <= '0;
                mid_cnt_reg  <= '0;
            end else begin
                if (feeding) begin
                    feed_cnt_reg <= feed_cnt_reg + 1'b1;
                end
                if (state_reg == S_FEED && mid.valid) begin
                    mid_cnt_reg <= mid_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            acc_reg <= '0;
        end else if (state_reg == S_FEED && mid.valid) begin
            acc_reg <= sum_final;
        end
    end

    // ---------------- sample ring ----------------
    // the ring shifts: slot 0 is the newest, the last slot the oldest;
    // a full rotation during the feed brings it back to the same order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
        end else if (in_accept) begin
            case (kind_t'(s_kind))
                KIND_SEED: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        ring_reg[i] <= s_sample;
                    end
                end
                KIND_SAMPLE: begin
                    if (s_sample != '0) begin
                        ring_reg[0] <= s_sample;
                        for (int i = 1; i < DEPTH; i++) begin
                            ring_reg[i] <= ring_reg[i-1];
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (feeding) begin
            ring_reg[0] <= ring_reg[DEPTH-1];
            for (int i = 1; i < DEPTH; i++) begin
                ring_reg[i] <= ring_reg[i-1];
            end
        end
    end

    // ---------------- sorter chain ----------------
    // first TR cells keep the lowest values, the next TR the highest;
    // what leaves the chain is the middle of the ring
    assign link[0].valid = feeding;
    assign link[0].data  = ring_reg[DEPTH-1];

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        tmtf_sort_cell #(
            .KEEP_LOW (k < TR)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .clear    (state_reg == S_IDLE),
            .link_in  (link[k]),
            .link_out (link[k+1])
        );
    end

    assign mid = link[NCELL];

    // ---------------- mean ----------------
    tmtf_div #(
        .DIVISOR    (NKEEP),
        .DIVIDEND_W (SUM_W),
        .QUOT_W     (10)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (last_mid),
        .dividend (sum_final),
        .quotient (div_q),
        .done     (div_done)
    );

    // ---------------- unit conversion ----------------
    assign kelvin_calc  = signed'({2'b00, div_q}) + 12'(adj_reg);
    assign celsius_calc = kelvin_calc - CELSIUS_OFFSET;
    assign cel_ext      = 15'(cel_reg);
    assign cel_x9       = (cel_ext <<< 3) + cel_ext;
    assign cel_x9_mag   = cel_x9[14] ? 15'(-cel_x9) : 15'(cel_x9);
    assign prod         = 29'(mag_reg) * 29'(RECIP5);
    assign fq           = signed'({1'b0, q_reg});
    // truncation toward zero: divide the magnitude, then restore the sign
    assign fahr_calc    = (neg_reg ? -fq : fq) + FAHRENHEIT_OFFSET;

    always_ff @(posedge aclk) begin
        if (state_reg == S_TEMP) begin
            kel_reg <= kelvin_calc;
            cel_reg <= celsius_calc[10:0];
        end
        if (state_reg == S_MAG) begin
            mag_reg <= cel_x9_mag[12:0];
            neg_reg <= cel_x9[14];
        end
        if (state_reg == S_MUL) begin
            q_reg <= prod[RECIP5_SHIFT +: 11];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
            m_kelvin_reg     <= kel_reg;
            m_celsius_reg    <= cel_reg;
            m_fahrenheit_reg <= fahr_calc;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kelvin     = m_kelvin_reg;
    assign m_celsius    = m_celsius_reg;
    assign m_fahrenheit = m_fahrenheit_reg;

    // ---------------- assertions ----------------
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    a_mid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FEED |-> mid_cnt_reg < MC_W'(NKEEP))
        else $error("more middle values than expected");

    a_full_rotation: assert property (@(posedge aclk) disable iff (!aresetn)
        last_mid |-> feed_cnt_reg == FC_W'(DEPTH - ((NCELL == 0) ? 1 : 0)))
        else $error("sum finished before the ring was fully rotated");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> state_reg == S_FEED && feed_cnt_reg == '0)
        else $error("accepted word did not start a feed");

    a_out_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && m_valid_reg && !m_ready) |=> state_reg == S_OUT)
        else $error("result dropped over a waiting word");

endmodule

`default_nettype wire
